// File: hw/rtl/rha_pkg.sv
package rha_pkg;

  localparam int HANDLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_ADD_REF  = 2'd1,
    KIND_DROP_REF = 2'd2,
    KIND_FREE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_FREED       = 3'd1,
    STAT_EXHAUSTED   = 3'd2,
    STAT_NOT_LIVE    = 3'd3,
    STAT_COUNT_LIMIT = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

// File: hw/rtl/refcounted_handle_allocator.sv
// Channel | Ports                                        | Direction
// in      | in_valid, in_ready, in_kind, in_handle       | request in
// out     | out_valid, out_ready, out_result_handle,     | result out
//         | out_status, out_ref_count_now                |
//
// The accept cycle reads the handle's entry from the entry RAM; the execute
// state then modifies it and writes it back. A new request is taken only in
// the idle state, so requests never overlap.
// The output register frees the input side: a request is taken while a
// result waits; only its write-back stalls until the output register is free.
// Reset clears the bump counter and the free list; no clearing pass. Entries
// at or above the bump counter were never handed out and read as not live.
module refcounted_handle_allocator
  import rha_pkg::*;
#(
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_kind,
  input  logic [HANDLE_BITS-1:0] in_handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HANDLE_BITS-1:0] out_result_handle,
  output logic [2:0]             out_status,
  output logic [COUNT_BITS-1:0]  out_ref_count_now
);

  localparam int HB    = HANDLE_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int DEPTH = 1 << HB;
  // entry: {live, next_valid, next_link, count}
  localparam int EW    = 2 + HB + CB;

  state_t            state_r, state_nxt;
  kind_t             kind_r;
  logic [HB-1:0]     h_r;
  logic [HB:0]       bump_r, bump_nxt;
  logic [HB-1:0]     head_r, head_nxt;
  logic              ne_r, ne_nxt;

  logic              out_valid_r;
  logic [HB-1:0]     res_h_r, res_h;
  status_t           res_stat_r, res_stat;
  logic [CB-1:0]     res_cnt_r, res_cnt;

  logic              accept, commit;
  logic              ram_we;
  logic [HB-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  logic              rd_live, rd_nv, live;
  logic [HB-1:0]     rd_link;
  logic [CB-1:0]     rd_cnt, cnt_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign ram_raddr = (kind_t'(in_kind) == KIND_ALLOC) ? head_r : in_handle;

  rha_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_live = ram_rdata[EW-1];
  assign rd_nv   = ram_rdata[EW-2];
  assign rd_link = ram_rdata[CB +: HB];
  assign rd_cnt  = ram_rdata[CB-1:0];
  assign cnt_dec = rd_cnt - {{(CB-1){1'b0}}, 1'b1};
  // entries at or above the bump counter were never written
  assign live    = rd_live && ({1'b0, h_r} < bump_r);

  always_comb begin
    state_nxt = state_r;
    bump_nxt  = bump_r;
    head_nxt  = head_r;
    ne_nxt    = ne_r;
    ram_we    = 1'b0;
    ram_waddr = h_r;
    ram_wdata = '0;
    res_h     = h_r;
    res_stat  = STAT_OK;
    res_cnt   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    unique case (kind_r)
      KIND_ALLOC: begin
        priority if (ne_r) begin
          res_h     = head_r;
          ram_waddr = head_r;
          ram_we    = 1'b1;
          ram_wdata = {1'b1, rd_nv, rd_link, {CB{1'b0}}};
          head_nxt  = rd_link;
          ne_nxt    = rd_nv;
        end else if (!bump_r[HB]) begin
          res_h     = bump_r[HB-1:0];
          ram_waddr = bump_r[HB-1:0];
          ram_we    = 1'b1;
          ram_wdata = {2'b10, {HB{1'b0}}, {CB{1'b0}}};
          bump_nxt  = bump_r + {{HB{1'b0}}, 1'b1};
        end else begin
          res_h    = '0;
          res_stat = STAT_EXHAUSTED;
        end
      end
      KIND_ADD_REF: begin
        priority if (!live) begin
          res_stat = STAT_NOT_LIVE;
        end else if (&rd_cnt) begin
          res_stat = STAT_COUNT_LIMIT;
          res_cnt  = rd_cnt;
        end else begin
          res_cnt   = rd_cnt + {{(CB-1){1'b0}}, 1'b1};
          ram_we    = 1'b1;
          ram_wdata = {1'b1, rd_nv, rd_link, res_cnt};
        end
      end
      KIND_DROP_REF: begin
        priority if (!live) begin
          res_stat = STAT_NOT_LIVE;
        end else if (rd_cnt == '0) begin
          res_stat = STAT_COUNT_LIMIT;
        end else if (cnt_dec == '0) begin
          res_stat  = STAT_FREED;
          ram_we    = 1'b1;
          ram_wdata = {1'b0, ne_r, head_r, {CB{1'b0}}};
          head_nxt  = h_r;
          ne_nxt    = 1'b1;
        end else begin
          res_cnt   = cnt_dec;
          ram_we    = 1'b1;
          ram_wdata = {1'b1, rd_nv, rd_link, cnt_dec};
        end
      end
      KIND_FREE: begin
        priority if (!live) begin
          res_stat = STAT_NOT_LIVE;
        end else if (rd_cnt == '0) begin
          res_stat  = STAT_FREED;
          ram_we    = 1'b1;
          ram_wdata = {1'b0, ne_r, head_r, {CB{1'b0}}};
          head_nxt  = h_r;
          ne_nxt    = 1'b1;
        end else begin
          res_cnt = rd_cnt;
        end
      end
      default: res_stat = STAT_OK;
    endcase

    if (!commit) begin
      ram_we   = 1'b0;
      bump_nxt = bump_r;
      head_nxt = head_r;
      ne_nxt   = ne_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bump_r      <= '0;
      head_r      <= '0;
      ne_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bump_r  <= bump_nxt;
      head_r  <= head_nxt;
      ne_r    <= ne_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      h_r    <= in_handle;
    end
    if (commit) begin
      res_h_r    <= res_h;
      res_stat_r <= res_stat;
      res_cnt_r  <= res_cnt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_handle = res_h_r;
  assign out_status        = res_stat_r;
  assign out_ref_count_now = res_cnt_r;

  a_bump_range: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= DEPTH[HB:0])
    else $error("bump counter past capacity");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EXEC) && commit)
    else $error("entry write outside write-back");

  a_freed_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (res_stat == STAT_FREED) |=> ne_r && (head_r == $past(h_r)))
    else $error("freed handle not on free list");

  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (res_stat == STAT_EXHAUSTED) |-> !ne_r && bump_r[HB])
    else $error("exhausted with handles left");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> !$past(commit) || $past(state_r == S_IDLE))
    else $error("result overwritten while waiting");

endmodule

// File: hw/rtl/rha_ram.sv
module rha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
